// ===== rtl/dpsca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsca_pkg
// Shared types, codes and helpers for the DRAM power state cycle accounter.
// ----------------------------------------------------------------------------
package dpsca_pkg;

    localparam int NUM_BANKS_DEF = 8;
    localparam int MAP_W         = 8;
    localparam int NUM_CNT       = 26;
    localparam int NUM_EVT       = 12;
    localparam int CFG_W         = 12;
    localparam int TS_W          = 47;
    localparam int CNT_W         = 48;
    localparam int EVT_W         = 49;
    localparam int WIDE_W        = 52;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 72;

    // event time slots
    localparam logic [3:0] T_FIRST_ACT = 4'd0;
    localparam logic [3:0] T_PDN       = 4'd1;
    localparam logic [3:0] T_SREF_WIN  = 4'd2;
    localparam logic [3:0] T_END_ACT   = 4'd3;
    localparam logic [3:0] T_END_RD    = 4'd4;
    localparam logic [3:0] T_END_WR    = 4'd5;
    localparam logic [3:0] T_LAT_RD    = 4'd6;
    localparam logic [3:0] T_LAT_WR    = 4'd7;
    localparam logic [3:0] T_LAT_PRE   = 4'd8;
    localparam logic [3:0] T_LAT_ACT   = 4'd9;
    localparam logic [3:0] T_SREF      = 4'd10;
    localparam logic [3:0] T_LAST_PRE  = 4'd11;

    localparam logic W_ACT = 1'b0;
    localparam logic W_PRE = 1'b1;

    // counter indexes
    localparam logic [4:0] C_ACTS       = 5'd0;
    localparam logic [4:0] C_PRES       = 5'd1;
    localparam logic [4:0] C_READS      = 5'd2;
    localparam logic [4:0] C_WRITES     = 5'd3;
    localparam logic [4:0] C_REFS       = 5'd4;
    localparam logic [4:0] C_PDN_FA     = 5'd5;
    localparam logic [4:0] C_PDN_SA     = 5'd6;
    localparam logic [4:0] C_PDN_FP     = 5'd7;
    localparam logic [4:0] C_PDN_SP     = 5'd8;
    localparam logic [4:0] C_SREFS      = 5'd9;
    localparam logic [4:0] C_ACT_CYC    = 5'd10;
    localparam logic [4:0] C_PRE_CYC    = 5'd11;
    localparam logic [4:0] C_PDN_BASE   = 5'd11;
    localparam logic [4:0] C_PDN_FA_CYC = 5'd12;
    localparam logic [4:0] C_PDN_SA_CYC = 5'd13;
    localparam logic [4:0] C_PDN_FP_CYC = 5'd14;
    localparam logic [4:0] C_PDN_SP_CYC = 5'd15;
    localparam logic [4:0] C_PUP_ACT    = 5'd16;
    localparam logic [4:0] C_PUP_PRE    = 5'd17;
    localparam logic [4:0] C_SREF_IDD6  = 5'd18;
    localparam logic [4:0] C_SREF_PUP   = 5'd19;
    localparam logic [4:0] C_SREF_RACT  = 5'd20;
    localparam logic [4:0] C_SREF_RPRE  = 5'd21;
    localparam logic [4:0] C_SRX_RACT   = 5'd22;
    localparam logic [4:0] C_SRX_RPRE   = 5'd23;
    localparam logic [4:0] C_ACT_IDLE   = 5'd24;
    localparam logic [4:0] C_PRE_IDLE   = 5'd25;

    // warning bits
    localparam int WB_PDN      = 0;
    localparam int WB_OPEN     = 1;
    localparam int WB_CLOSED   = 2;
    localparam int WB_BANKS    = 3;
    localparam int WB_PRECH    = 4;
    localparam int WB_ALLPRE   = 5;
    localparam int WB_NONE     = 6;
    localparam int WB_PUP_ACT  = 7;
    localparam int WB_PUP_PRE  = 8;
    localparam int WB_SREX     = 9;

    // config register indexes
    localparam logic [2:0] R_READ_DONE  = 3'd0;
    localparam logic [2:0] R_WRITE_DONE = 3'd1;
    localparam logic [2:0] R_ACT_TO_RW  = 3'd2;
    localparam logic [2:0] R_PRECHARGE  = 3'd3;
    localparam logic [2:0] R_REFRESH    = 3'd4;
    localparam logic [2:0] R_FAST_EXIT  = 3'd5;
    localparam logic [2:0] R_SLOW_EXIT  = 3'd6;
    localparam logic [2:0] R_SREF_EXIT  = 3'd7;

    typedef enum logic [4:0] {
        A_ACT     = 5'd0,
        A_RD      = 5'd1,
        A_WR      = 5'd2,
        A_REF     = 5'd3,
        A_PRE     = 5'd4,
        A_PREA    = 5'd5,
        A_PDN_FA  = 5'd6,
        A_PDN_SA  = 5'd7,
        A_PDN_FP  = 5'd8,
        A_PDN_SP  = 5'd9,
        A_PUP_ACT = 5'd10,
        A_PUP_PRE = 5'd11,
        A_SREN    = 5'd12,
        A_SREX    = 5'd13,
        A_END     = 5'd14,
        A_READ    = 5'd15,
        A_CLEAR   = 5'd16
    } action_e;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_PDN_FA = 3'd1,
        M_PDN_SA = 3'd2,
        M_PDN_FP = 3'd3,
        M_PDN_SP = 3'd4,
        M_SREF   = 3'd5
    } mode_e;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic [CFG_W-1:0] read_done;
        logic [CFG_W-1:0] write_done;
        logic [CFG_W-1:0] act_to_rw;
        logic [CFG_W-1:0] precharge;
        logic [CFG_W-1:0] refresh;
        logic [CFG_W-1:0] fast_exit;
        logic [CFG_W-1:0] slow_exit;
        logic [CFG_W-1:0] sref_exit;
    } cfg_t;

    typedef struct packed {
        logic [4:0]      action;
        logic [2:0]      bank;
        logic [TS_W-1:0] timestamp;
        logic [4:0]      counter_index;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] counter_value;
        logic [9:0]       warnings;
        logic [3:0]       active_banks;
        logic [2:0]       power_mode;
    } result_t;

    typedef struct packed {
        logic [MAP_W-1:0]               bank_map;
        logic [MAP_W-1:0]               saved_map;
        mode_e                          mode;
        logic [NUM_EVT-1:0][EVT_W-1:0]  evt;
        logic [1:0][CNT_W-1:0]          tally;
    } acc_state_t;

    function automatic wide_t sx49(input logic [EVT_W-1:0] v);
        return {{(WIDE_W-EVT_W){v[EVT_W-1]}}, v};
    endfunction

    function automatic wide_t sx48(input logic [CNT_W-1:0] v);
        return {{(WIDE_W-CNT_W){v[CNT_W-1]}}, v};
    endfunction

    function automatic wide_t ux12(input logic [CFG_W-1:0] v);
        return {{(WIDE_W-CFG_W){1'b0}}, v};
    endfunction

    function automatic wide_t pos(input wide_t v);
        return (v > 0) ? v : '0;
    endfunction

    function automatic wide_t mx(input wide_t a, input wide_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [3:0] popcnt(input logic [MAP_W-1:0] m);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < MAP_W; i++)
            n = n + {3'b0, m[i]};
        return n;
    endfunction

endpackage

// ===== rtl/dram_power_state_cycle_accounter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dram_power_state_cycle_accounter_unit
// DRAM power-state residency and command counter with windowed clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transfer (action, bank, issue cycle, counter
//   index). Every command yields exactly one result transfer on m_*: the
//   counter value (read action only), the warning mask, the open-bank count
//   and the power mode after the command.
//   cfg_* writes the eight 12-bit timing registers; cfg_ready is always high.
//   Write them only while no command is in flight.
// Timing:
//   Two register stages: input register, then the result register that also
//   commits the bank map, mode, event times and the 26 counters. m_tvalid
//   rises once a command has passed the input register into the result
//   register; one command per cycle is sustained while m_tready stays high.
// Reset:
//   rst_n clears both stages, bank maps, mode, counters and event times, but
//   sets the latest-command times to all ones; timing registers get defaults.
// Backpressure:
//   While m_tready is low the result register holds; the input register
//   keeps its command and s_tready drops once it is also full.
// ----------------------------------------------------------------------------
module dram_power_state_cycle_accounter_unit import dpsca_pkg::*; #(
    parameter int NUM_BANKS = NUM_BANKS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [4:0] action, [7:5] bank, [54:8] timestamp, [59:55] counter_index
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [47:0] counter_value, [57:48] warnings, [61:58] active_banks,
    // [64:62] power_mode
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    cfg_t       cfg;
    item_t      in_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    acc_state_t st_reg;
    acc_state_t st_next;
    logic [CNT_W-1:0] cnt_reg [NUM_CNT];
    logic [NUM_CNT-1:0][CNT_W-1:0] delta;
    logic       clr;
    logic       adv;
    logic [CNT_W-1:0] cnt_rd;

    dpsca_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage advance: result register empty or being drained
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // counter readback mux, out-of-range index reads zero
    assign cnt_rd = (in_reg.counter_index < 5'(NUM_CNT)) ? cnt_reg[in_reg.counter_index] : '0;

    dpsca_step #(
        .NUM_BANKS (NUM_BANKS)
    ) u_step (
        .st      (st_reg),
        .cfg     (cfg),
        .item    (in_reg),
        .cnt_rd  (cnt_rd),
        .st_next (st_next),
        .delta   (delta),
        .clr     (clr),
        .res     (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // unpack tdata field by field, action in the lowest bits
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.action        <= s_tdata[4:0];
            in_reg.bank          <= s_tdata[7:5];
            in_reg.timestamp     <= s_tdata[54:8];
            in_reg.counter_index <= s_tdata[59:55];
        end
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.bank_map  <= '0;
            st_reg.saved_map <= '0;
            st_reg.mode      <= M_NORMAL;
            st_reg.evt       <= '0;
            st_reg.evt[T_LAT_RD]  <= '1;
            st_reg.evt[T_LAT_WR]  <= '1;
            st_reg.evt[T_LAT_PRE] <= '1;
            st_reg.evt[T_LAT_ACT] <= '1;
            st_reg.tally     <= '0;
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= '0;
        end
        else if (adv)
        begin
            st_reg <= st_next;
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= clr ? '0 : cnt_reg[i] + delta[i];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.power_mode, out_reg.active_banks,
                       out_reg.warnings, out_reg.counter_value};

endmodule

// ===== rtl/dpsca_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsca_cfg
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module dpsca_cfg import dpsca_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_done  <= 12'd15;
            cfg_reg.write_done <= 12'd25;
            cfg_reg.act_to_rw  <= 12'd11;
            cfg_reg.precharge  <= 12'd11;
            cfg_reg.refresh    <= 12'd128;
            cfg_reg.fast_exit  <= 12'd5;
            cfg_reg.slow_exit  <= 12'd20;
            cfg_reg.sref_exit  <= 12'd140;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                R_READ_DONE:  cfg_reg.read_done  <= cfg_data;
                R_WRITE_DONE: cfg_reg.write_done <= cfg_data;
                R_ACT_TO_RW:  cfg_reg.act_to_rw  <= cfg_data;
                R_PRECHARGE:  cfg_reg.precharge  <= cfg_data;
                R_REFRESH:    cfg_reg.refresh    <= cfg_data;
                R_FAST_EXIT:  cfg_reg.fast_exit  <= cfg_data;
                R_SLOW_EXIT:  cfg_reg.slow_exit  <= cfg_data;
                R_SREF_EXIT:  cfg_reg.sref_exit  <= cfg_data;
                default:      cfg_reg            <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/dpsca_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsca_step
// Next-state and result logic for one command.
// ----------------------------------------------------------------------------
module dpsca_step import dpsca_pkg::*; #(
    parameter int NUM_BANKS = NUM_BANKS_DEF
) (
    input  acc_state_t                   st,
    input  cfg_t                         cfg,
    input  item_t                        item,
    input  logic [CNT_W-1:0]             cnt_rd,
    output acc_state_t                   st_next,
    output logic [NUM_CNT-1:0][CNT_W-1:0] delta,
    output logic                         clr,
    output result_t                      res
);

    wide_t ts, rp, rfc, ra, sx, sc, dur, win, wa, wp, tmp, ex;
    wide_t lat_rd, lat_wr, lat_act, lat_pre, end_rd, end_wr, end_act;
    wide_t ia_d, ip_d, act_cyc, pre_cyc;
    logic  bank_ok, is_open, ign;
    logic [MAP_W-1:0] bbit, bmask;
    logic [3:0] nact;
    logic [9:0] warn;
    logic [CNT_W-1:0] cval;
    action_e act;

    always_comb
    begin
        st_next = st;
        delta   = '0;
        clr     = 1'b0;
        warn    = '0;
        cval    = '0;
        act     = action_e'(item.action);

        ts  = {{(WIDE_W-TS_W){1'b0}}, item.timestamp};
        rp  = ux12(cfg.precharge);
        rfc = ux12(cfg.refresh);
        ra  = rfc - rp;
        sx  = ux12(cfg.sref_exit);
        sc  = sx49(st.evt[T_SREF]);
        win = sx49(st.evt[T_SREF_WIN]);
        wa  = sx48(st.tally[W_ACT]);
        wp  = sx48(st.tally[W_PRE]);
        dur = '0;
        tmp = '0;
        ex  = '0;

        nact    = popcnt(st.bank_map);
        bank_ok = {29'b0, item.bank} < NUM_BANKS;
        bbit    = MAP_W'(1) << item.bank;
        is_open = |(st.bank_map & bbit);
        for (int i = 0; i < MAP_W; i++)
            bmask[i] = (i < NUM_BANKS);

        // idle-active bookkeeping always starts from the state before the command
        lat_rd  = sx49(st.evt[T_LAT_RD]);
        lat_wr  = sx49(st.evt[T_LAT_WR]);
        lat_act = sx49(st.evt[T_LAT_ACT]);
        lat_pre = sx49(st.evt[T_LAT_PRE]);
        end_rd  = (lat_rd >= 0)
                  ? sx49(EVT_W'(lat_rd + ux12(cfg.read_done) - 1)) : sx49(st.evt[T_END_RD]);
        end_wr  = (lat_wr >= 0)
                  ? sx49(EVT_W'(lat_wr + ux12(cfg.write_done) - 1)) : sx49(st.evt[T_END_WR]);
        end_act = (lat_act >= 0)
                  ? sx49(EVT_W'(lat_act + ux12(cfg.act_to_rw) - 1)) : sx49(st.evt[T_END_ACT]);
        ia_d    = pos(ts - mx(mx(end_rd, end_wr), end_act));

        if (lat_pre > 0)
            ip_d = pos(ts - lat_pre - rp);
        else if (lat_pre == 0)
            ip_d = pos(ts);
        else
            ip_d = '0;

        act_cyc = pos(ts - sx49(st.evt[T_FIRST_ACT]));
        pre_cyc = pos(ts - sx49(st.evt[T_LAST_PRE]));

        ign = ((act == A_ACT) || (act == A_RD) || (act == A_WR) || (act == A_PRE)) && !bank_ok;
        if (!ign && (item.action <= 5'(A_PREA)) && (st.mode != M_NORMAL))
            warn[WB_PDN] = 1'b1;

        if (!ign)
        begin
            unique case (act)
                A_ACT:
                begin
                    if (!is_open)
                    begin
                        delta[C_ACTS] = CNT_W'(1);
                        if (nact == 4'd0)
                        begin
                            st_next.evt[T_FIRST_ACT] = EVT_W'(ts);
                            delta[C_PRE_CYC] = CNT_W'(pre_cyc);
                            delta[C_PRE_IDLE] = CNT_W'(ip_d);
                        end
                        st_next.bank_map = st.bank_map | bbit;
                        st_next.evt[T_LAT_ACT] = EVT_W'(ts);
                    end
                    else
                        warn[WB_OPEN] = 1'b1;
                end
                A_RD, A_WR:
                begin
                    if (!is_open)
                        warn[WB_CLOSED] = 1'b1;
                    delta[(act == A_RD) ? C_READS : C_WRITES] = CNT_W'(1);
                    st_next.evt[T_END_RD]  = EVT_W'(end_rd);
                    st_next.evt[T_END_WR]  = EVT_W'(end_wr);
                    st_next.evt[T_END_ACT] = EVT_W'(end_act);
                    delta[C_ACT_IDLE] = CNT_W'(ia_d);
                    st_next.evt[(act == A_RD) ? T_LAT_RD : T_LAT_WR] = EVT_W'(ts);
                end
                A_REF:
                begin
                    if (nact != 4'd0)
                        warn[WB_BANKS] = 1'b1;
                    delta[C_REFS]     = CNT_W'(1);
                    delta[C_PRE_IDLE] = CNT_W'(ip_d);
                    st_next.evt[T_FIRST_ACT] = EVT_W'(ts);
                    delta[C_PRE_CYC]  = CNT_W'(pre_cyc);
                    st_next.evt[T_LAST_PRE] = EVT_W'(ts + ra);
                    st_next.evt[T_LAT_PRE]  = EVT_W'(ts + ra);
                    delta[C_ACT_CYC]  = CNT_W'(ra);
                    st_next.bank_map  = '0;
                end
                A_PRE:
                begin
                    if (is_open)
                    begin
                        delta[C_PRES] = CNT_W'(1);
                        if (nact == 4'd1)
                        begin
                            delta[C_ACT_CYC] = CNT_W'(act_cyc);
                            st_next.evt[T_LAST_PRE] = EVT_W'(ts);
                            st_next.evt[T_END_RD]   = EVT_W'(end_rd);
                            st_next.evt[T_END_WR]   = EVT_W'(end_wr);
                            st_next.evt[T_END_ACT]  = EVT_W'(end_act);
                            delta[C_ACT_IDLE] = CNT_W'(ia_d);
                        end
                        st_next.bank_map = st.bank_map & ~bbit;
                        st_next.evt[T_LAT_PRE] = EVT_W'(ts);
                    end
                    else
                        warn[WB_PRECH] = 1'b1;
                end
                A_PREA:
                begin
                    if (nact != 4'd0)
                    begin
                        delta[C_PRES]    = CNT_W'(nact);
                        delta[C_ACT_CYC] = CNT_W'(act_cyc);
                        st_next.evt[T_LAST_PRE] = EVT_W'(ts);
                        st_next.evt[T_END_RD]   = EVT_W'(end_rd);
                        st_next.evt[T_END_WR]   = EVT_W'(end_wr);
                        st_next.evt[T_END_ACT]  = EVT_W'(end_act);
                        delta[C_ACT_IDLE] = CNT_W'(ia_d);
                        st_next.evt[T_LAT_PRE]  = EVT_W'(ts);
                        st_next.bank_map = '0;
                    end
                    else
                        warn[WB_ALLPRE] = 1'b1;
                end
                A_PDN_FA, A_PDN_SA:
                begin
                    if (nact == 4'd0)
                        warn[WB_NONE] = 1'b1;
                    delta[(act == A_PDN_FA) ? C_PDN_FA : C_PDN_SA] = CNT_W'(1);
                    st_next.saved_map = st.bank_map;
                    st_next.evt[T_PDN] = EVT_W'(ts);
                    delta[C_ACT_CYC] = CNT_W'(act_cyc);
                    st_next.evt[T_END_RD]  = EVT_W'(end_rd);
                    st_next.evt[T_END_WR]  = EVT_W'(end_wr);
                    st_next.evt[T_END_ACT] = EVT_W'(end_act);
                    delta[C_ACT_IDLE] = CNT_W'(ia_d);
                    st_next.mode = (act == A_PDN_FA) ? M_PDN_FA : M_PDN_SA;
                end
                A_PDN_FP, A_PDN_SP:
                begin
                    if (nact != 4'd0)
                        warn[WB_BANKS] = 1'b1;
                    delta[(act == A_PDN_FP) ? C_PDN_FP : C_PDN_SP] = CNT_W'(1);
                    st_next.evt[T_PDN] = EVT_W'(ts);
                    delta[C_PRE_CYC]  = CNT_W'(pre_cyc);
                    delta[C_PRE_IDLE] = CNT_W'(ip_d);
                    st_next.mode = (act == A_PDN_FP) ? M_PDN_FP : M_PDN_SP;
                end
                A_PUP_ACT:
                begin
                    if ((st.mode == M_PDN_FA) || (st.mode == M_PDN_SA))
                    begin
                        ex = ux12((st.mode == M_PDN_FA) ? cfg.fast_exit : cfg.slow_exit);
                        delta[(st.mode == M_PDN_FA) ? C_PDN_FA_CYC : C_PDN_SA_CYC] =
                            CNT_W'(pos(ts - sx49(st.evt[T_PDN])));
                        delta[C_PUP_ACT] = CNT_W'(ex);
                        st_next.evt[T_LAT_ACT] = EVT_W'(mx(ts, ts + ex - ux12(cfg.act_to_rw)));
                    end
                    else
                        warn[WB_PUP_ACT] = 1'b1;
                    st_next.mode = M_NORMAL;
                    st_next.bank_map = st.saved_map & bmask;
                    st_next.evt[T_FIRST_ACT] = EVT_W'(ts);
                end
                A_PUP_PRE:
                begin
                    if ((st.mode == M_PDN_FP) || (st.mode == M_PDN_SP))
                    begin
                        ex = ux12((st.mode == M_PDN_FP) ? cfg.fast_exit : cfg.slow_exit);
                        delta[(st.mode == M_PDN_FP) ? C_PDN_FP_CYC : C_PDN_SP_CYC] =
                            CNT_W'(pos(ts - sx49(st.evt[T_PDN])));
                        delta[C_PUP_PRE] = CNT_W'(ex);
                        st_next.evt[T_LAT_PRE] = EVT_W'(mx(ts, ts + ex - rp));
                    end
                    else
                        warn[WB_PUP_PRE] = 1'b1;
                    st_next.mode = M_NORMAL;
                    st_next.evt[T_LAST_PRE] = EVT_W'(ts);
                end
                A_SREN:
                begin
                    if (nact != 4'd0)
                        warn[WB_BANKS] = 1'b1;
                    delta[C_SREFS] = CNT_W'(1);
                    st_next.evt[T_SREF]     = EVT_W'(ts);
                    st_next.evt[T_SREF_WIN] = EVT_W'(ts);
                    st_next.tally = '0;
                    delta[C_PRE_CYC]  = CNT_W'(pre_cyc);
                    delta[C_PRE_IDLE] = CNT_W'(ip_d);
                    st_next.mode = M_SREF;
                end
                A_SREX:
                begin
                    dur = ts - sc;
                    if (st.mode != M_SREF)
                        warn[WB_SREX] = 1'b1;
                    if (dur <= 0)
                    begin
                        warn[WB_SREX] = 1'b1;
                        dur = '0;
                    end
                    if (dur >= rfc)
                    begin
                        delta[C_SREF_RACT] = CNT_W'(ra - wa);
                        delta[C_SREF_RPRE] = CNT_W'(rp - wp);
                        st_next.evt[T_LAST_PRE] = EVT_W'(ts);
                        if (win > sc + rfc)
                            delta[C_SREF_IDD6] = CNT_W'(pos(ts - win));
                        else
                            delta[C_SREF_IDD6] = CNT_W'(pos(ts - sc - rfc));
                        delta[C_SREF_PUP] = CNT_W'(sx);
                        st_next.evt[T_LAT_PRE] = EVT_W'(mx(ts, ts + sx - rp));
                    end
                    else if (dur >= ra)
                    begin
                        // tmp: precharge part already spent inside the refresh
                        tmp = dur - ra - wp;
                        delta[C_SREF_RACT] = CNT_W'(ra - wa);
                        delta[C_SREF_RPRE] = CNT_W'(tmp);
                        tmp = rp - tmp;
                        delta[C_SRX_RPRE] = CNT_W'(tmp);
                        st_next.evt[T_LAST_PRE] = EVT_W'(ts + tmp);
                        delta[C_SREF_PUP] = CNT_W'(sx - tmp);
                        st_next.evt[T_LAT_PRE] = EVT_W'(mx(ts, ts + sx - tmp - rp));
                    end
                    else
                    begin
                        tmp = ra - dur;
                        delta[C_SREF_RACT] = CNT_W'(dur - wa);
                        delta[C_SRX_RACT]  = CNT_W'(tmp);
                        delta[C_SRX_RPRE]  = CNT_W'(rp);
                        st_next.evt[T_LAST_PRE] = EVT_W'(ts + tmp + rp);
                        delta[C_SREF_PUP] = CNT_W'(sx - tmp - rp);
                        st_next.evt[T_LAT_PRE] = EVT_W'(mx(ts, ts + sx - tmp - rp - rp));
                    end
                    st_next.mode = M_NORMAL;
                end
                A_END:
                begin
                    if ((st.mode == M_NORMAL) && (nact != 4'd0))
                    begin
                        delta[C_ACT_CYC] = CNT_W'(act_cyc);
                        st_next.evt[T_END_RD]  = EVT_W'(end_rd);
                        st_next.evt[T_END_WR]  = EVT_W'(end_wr);
                        st_next.evt[T_END_ACT] = EVT_W'(end_act);
                        delta[C_ACT_IDLE] = CNT_W'(ia_d);
                    end
                    else if (st.mode == M_NORMAL)
                    begin
                        delta[C_PRE_CYC]  = CNT_W'(pre_cyc);
                        delta[C_PRE_IDLE] = CNT_W'(ip_d);
                    end
                    else if (st.mode == M_SREF)
                    begin
                        // split the self-refresh time seen so far into its phases
                        if (ts > sc + rfc)
                        begin
                            if (win <= sc + ra)
                            begin
                                delta[C_SREF_RACT] = CNT_W'(ra - wa);
                                wa  = ra;
                                win = sx49(EVT_W'(sc + ra));
                            end
                            if (win <= sc + rfc)
                            begin
                                delta[C_SREF_RPRE] = CNT_W'(rp - wp);
                                wp  = rp;
                                win = sx49(EVT_W'(sc + rfc));
                            end
                            delta[C_SREF_IDD6] = CNT_W'(pos(ts - win));
                        end
                        else if (ts > sc + ra)
                        begin
                            if (win <= sc + ra)
                            begin
                                delta[C_SREF_RACT] = CNT_W'(ra - wa);
                                wa  = ra;
                                win = sx49(EVT_W'(sc + ra));
                            end
                            wp = wp + ts - win;
                            delta[C_SREF_RPRE] = CNT_W'(ts - win);
                        end
                        else
                        begin
                            wa = wa + ts - win;
                            delta[C_SREF_RACT] = CNT_W'(ts - win);
                        end
                        st_next.tally[W_ACT]    = CNT_W'(wa);
                        st_next.tally[W_PRE]    = CNT_W'(wp);
                        st_next.evt[T_SREF_WIN] = EVT_W'(win);
                    end
                    else
                        delta[C_PDN_BASE + 5'(st.mode)] = CNT_W'(pos(ts - sx49(st.evt[T_PDN])));
                end
                A_READ:
                    cval = cnt_rd;
                A_CLEAR:
                begin
                    clr = 1'b1;
                    st_next.evt[T_FIRST_ACT] = EVT_W'(ts);
                    st_next.evt[T_PDN]       = EVT_W'(ts);
                    st_next.evt[T_SREF_WIN]  = EVT_W'(ts);
                    st_next.evt[T_END_ACT]   = EVT_W'(ts);
                    st_next.evt[T_END_RD]    = EVT_W'(ts);
                    st_next.evt[T_END_WR]    = EVT_W'(ts);
                    st_next.evt[T_LAT_RD]    = '1;
                    st_next.evt[T_LAT_WR]    = '1;
                    if (item.timestamp == '0)
                    begin
                        st_next.evt[T_LAT_PRE]  = '1;
                        st_next.evt[T_LAT_ACT]  = '1;
                        st_next.evt[T_SREF]     = '0;
                        st_next.evt[T_LAST_PRE] = '0;
                        st_next.tally           = '0;
                    end
                    else
                    begin
                        st_next.evt[T_LAST_PRE] = EVT_W'(mx(ts, sx49(st.evt[T_LAST_PRE])));
                        st_next.evt[T_LAT_PRE]  = EVT_W'(mx(ts, lat_pre));
                        if (lat_act < ts)
                            st_next.evt[T_LAT_ACT] = '1;
                    end
                end
                default:
                    st_next = st;
            endcase
        end

        res.counter_value = cval;
        res.warnings      = warn;
        res.active_banks  = popcnt(st_next.bank_map);
        res.power_mode    = st_next.mode;
    end

endmodule

// ===== rtl/dpsca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsca_checker
// Port-level checks for the accounter, bound to the top level.
// ----------------------------------------------------------------------------
module dpsca_checker import dpsca_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a counter readback never carries warnings
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[47:0] != 48'd0) |-> (m_tdata[57:48] == 10'd0))
        else $error("warnings on counter readback");

    // open-bank count within the bank map width
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[61] && (m_tdata[60:58] != 3'd0)))
        else $error("open-bank count out of range");

    // only six power modes exist
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[64:62] != 3'd6) && (m_tdata[64:62] != 3'd7))
        else $error("power mode out of range");

endmodule

bind dram_power_state_cycle_accounter_unit dpsca_checker u_dpsca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
